@@ design/pip_pkg.sv @@
// Shared types, widths and codes for the point-in-polygon test block.
`default_nettype none

package pip_pkg;

  // Field widths fixed by the interface
  localparam int COORD_W          = 16;
  localparam int DIFF_W           = COORD_W + 1;
  localparam int PROD_W           = 2 * DIFF_W;
  localparam int INDEX_W          = 6;
  localparam int VERTEX_COUNT_W   = 7;
  localparam int IN_TDATA_W       = 40;  // 38 payload bits padded to bytes
  localparam int OUT_TDATA_W      = 8;
  localparam int MAX_VERTICES_DEF = 64;

  // Kind codes carried in tuser
  localparam logic KIND_STORE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // One stored vertex, x in the low half
  typedef struct packed {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } vertex_t;

  // Walk control that rides along with a memory read
  typedef struct packed {
    logic valid;  // read data is on the bus this cycle
    logic first;  // wrap vertex: only primes the previous-vertex register
    logic last;   // final edge of the walk
  } edge_req_t;

  // Per-edge outcome from the crossing unit
  typedef struct packed {
    logic valid;
    logic toggle;
    logic last;
  } edge_res_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WALK  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_FIN   = 4'b1000
  } pip_state_e;

endpackage : pip_pkg

`default_nettype wire

@@ design/pip_edge.sv @@
// Two-stage edge crossing unit: straddle test, cross products, signed compare.
`default_nettype none

module pip_edge
  import pip_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire edge_req_t                 req_i,
  input  wire vertex_t                   cur_i,
  input  wire logic signed [COORD_W-1:0] px_i,
  input  wire logic signed [COORD_W-1:0] py_i,
  output edge_res_t                      res_o
);

  vertex_t                   prev_q;
  logic                      v2_q, last2_q, strad_q, dypos_q;
  logic signed [PROD_W-1:0]  lhs_q, rhs_q;

  logic                      strad;
  logic signed [DIFF_W-1:0]  dy, ey, ex, px_d;
  logic signed [PROD_W-1:0]  lhs, rhs;

  // Stage 1: edge (i = cur, j = prev)
  always_comb begin
    strad = ((cur_i.y < py_i) && (prev_q.y >= py_i)) ||
            ((prev_q.y < py_i) && (cur_i.y >= py_i));
    dy    = DIFF_W'(prev_q.y) - DIFF_W'(cur_i.y);
    ey    = DIFF_W'(py_i) - DIFF_W'(cur_i.y);
    ex    = DIFF_W'(prev_q.x) - DIFF_W'(cur_i.x);
    px_d  = DIFF_W'(px_i) - DIFF_W'(cur_i.x);
    lhs   = PROD_W'(ey) * PROD_W'(ex);
    rhs   = PROD_W'(px_d) * PROD_W'(dy);
  end

  // Previous vertex register and product pipeline (payload, no reset)
  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      prev_q <= cur_i;
    end
    lhs_q   <= lhs;
    rhs_q   <= rhs;
    strad_q <= strad;
    dypos_q <= ~dy[DIFF_W-1];
  end

  // Stage 2 valid tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q    <= 1'b0;
      last2_q <= 1'b0;
    end else begin
      v2_q    <= req_i.valid & ~req_i.first;
      last2_q <= req_i.last;
    end
  end

  // Stage 2: sign-corrected compare; dy is nonzero whenever the edge straddles
  always_comb begin
    res_o.valid  = v2_q;
    res_o.last   = last2_q;
    res_o.toggle = strad_q & (dypos_q ? (lhs_q < rhs_q) : (lhs_q > rhs_q));
  end

endmodule : pip_edge

`default_nettype wire

@@ design/point_in_polygon_test.sv @@
// Top level: vertex memory, edge walk sequencer and result register.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------
//  s_axis   | in        | tvalid / tready    | tuser: kind; tdata: index, x, y
//  m_axis   | out       | tvalid / tready    | tdata: inside_res
//  cfg      | in        | valid / ready      | vertex_count
//
// A store transaction writes one memory word when its index is below MAX_VERTICES.
// A query holds tready low while it runs (n = saturated vertex_count): n + 1
// reads of the single read port (wrap vertex first, then one edge per read), two
// stages of product/compare and a load of the result register; a query with n = 0
// skips the reads and only loads the result. The result appears as tready returns.
// Reset clears control state and vertex_count; vertex memory is not cleared.
// A query waits in its final state while the previous result is unclaimed.
`default_nettype none

module point_in_polygon_test
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  wire logic [IN_TDATA_W-1:0]     s_axis_tdata_i,  // [5:0] vertex_index, [21:6] coord_x,
                                                          // [37:22] coord_y, [39:38] zero
  input  wire logic [0:0]                s_axis_tuser_i,  // [0] kind
  output logic                           m_axis_tvalid_o,
  input  wire logic                      m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0]         m_axis_tdata_o,  // [0] inside_res, [7:1] zero
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [VERTEX_COUNT_W-1:0] cfg_data_i
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int NW = (CW > VERTEX_COUNT_W) ? CW : VERTEX_COUNT_W;
  localparam int IW = (AW + 1 > INDEX_W) ? AW + 1 : INDEX_W;

  pip_state_e                  state_q, state_d;
  logic [VERTEX_COUNT_W-1:0]   vcount_q;
  logic [CW-1:0]               n_q, rd_cnt_q;
  logic                        odd_q;
  logic                        out_valid_q, out_data_q;
  logic signed [COORD_W-1:0]   px_q, py_q;
  logic                        v1_q, first1_q, last1_q;

  vertex_t                     mem [MAX_VERTICES];
  vertex_t                     rdata_q;

  logic                        s_fire, query_fire, store_fire;
  logic [INDEX_W-1:0]          in_index;
  vertex_t                     in_vertex;
  logic [IW-1:0]               idx_ext;
  logic [NW-1:0]               cnt_ext, cnt_sat;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic                        out_load;
  edge_req_t                   req;
  edge_res_t                   res;

  // Input unpacking and handshakes
  assign in_index        = s_axis_tdata_i[INDEX_W-1:0];
  assign in_vertex.x     = s_axis_tdata_i[INDEX_W +: COORD_W];
  assign in_vertex.y     = s_axis_tdata_i[INDEX_W+COORD_W +: COORD_W];
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_fire          = s_axis_tvalid_i & s_axis_tready_o;
  assign query_fire      = s_fire & (s_axis_tuser_i[0] == KIND_QUERY);
  assign store_fire      = s_fire & (s_axis_tuser_i[0] == KIND_STORE);
  assign idx_ext         = IW'(in_index);
  assign cfg_ready_o     = 1'b1;

  // Vertex count saturated to the memory depth
  assign cnt_ext = NW'(vcount_q);
  assign cnt_sat = (cnt_ext > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : cnt_ext;

  // Read schedule: wrap vertex n-1 first, then 0 .. n-1
  assign rd_en   = (state_q == ST_WALK);
  assign rd_addr = (rd_cnt_q == '0) ? AW'(n_q - CW'(1)) : AW'(rd_cnt_q - CW'(1));

  // Vertex memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (store_fire && (idx_ext < IW'(MAX_VERTICES))) begin
      mem[AW'(idx_ext)] <= in_vertex;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Query point (payload)
  always_ff @(posedge clk_i) begin
    if (query_fire) begin
      px_q <= in_vertex.x;
      py_q <= in_vertex.y;
    end
  end

  assign req.valid = v1_q;
  assign req.first = first1_q;
  assign req.last  = last1_q;

  pip_edge u_edge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .cur_i  (rdata_q),
    .px_i   (px_q),
    .py_i   (py_q),
    .res_o  (res)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (query_fire) begin
          state_d = (cnt_sat == '0) ? ST_FIN : ST_WALK;
        end
      end
      ST_WALK: begin
        if (rd_cnt_q == n_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (res.valid && res.last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_load = (state_q == ST_FIN) & (~out_valid_q | m_axis_tready_i);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vcount_q    <= '0;
      n_q         <= '0;
      rd_cnt_q    <= '0;
      odd_q       <= 1'b0;
      v1_q        <= 1'b0;
      first1_q    <= 1'b0;
      last1_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        vcount_q <= cfg_data_i;
      end
      if (query_fire) begin
        n_q      <= CW'(cnt_sat);
        rd_cnt_q <= '0;
      end else if (rd_en) begin
        rd_cnt_q <= rd_cnt_q + CW'(1);
      end
      v1_q     <= rd_en;
      first1_q <= rd_en & (rd_cnt_q == '0);
      last1_q  <= rd_en & (rd_cnt_q == n_q);
      // even-odd accumulator
      if (query_fire) begin
        odd_q <= 1'b0;
      end else if (res.valid && res.toggle) begin
        odd_q <= ~odd_q;
      end
      // result register
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_data_q  <= odd_q;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W-1){1'b0}}, out_data_q};

endmodule : point_in_polygon_test

`default_nettype wire

@@ design/pip_checker.sv @@
// Port-level checker for the point-in-polygon test block, with its bind.
`default_nettype none

module pip_checker
  import pip_pkg::*;
(
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      s_axis_tvalid_i,
  input wire logic                      s_axis_tready_o,
  input wire logic [0:0]                s_axis_tuser_i,
  input wire logic                      m_axis_tvalid_o,
  input wire logic                      m_axis_tready_i,
  input wire logic [OUT_TDATA_W-1:0]    m_axis_tdata_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // A query transaction makes the block busy
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i[0] == KIND_QUERY)
    |=> !s_axis_tready_o)
    else $error("query accepted without going busy");

  // A store transaction never creates a result
  a_store_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i[0] == KIND_STORE)
    && !m_axis_tvalid_o |=> !m_axis_tvalid_o)
    else $error("store produced a result");

  // Padding bits of the result stay zero
  a_out_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[OUT_TDATA_W-1:1] == '0))
    else $error("result padding not zero");

endmodule : pip_checker

bind point_in_polygon_test pip_checker u_pip_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
